### hdl/cpf_pkg.sv
// shared types and constants for the length-prefixed chunk framer
package cpf_pkg;

  localparam int unsigned ByteW = 8;

  // what an issued output word carries
  typedef enum logic [1:0] {
    KIND_LEN,
    KIND_DATA,
    KIND_TERM
  } kind_e;

  // chunk hand-over from the writer to the reader
  typedef struct packed {
    logic             valid;
    logic             bank;
    logic [ByteW-1:0] count;
    logic             term;
  } chunk_close_t;

endpackage

### hdl/cpf_chunk_ram.sv
// two-bank chunk buffer: one write port, one registered read port
module cpf_chunk_ram #(
  parameter int unsigned AddrW = 5
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic [cpf_pkg::ByteW-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [AddrW-1:0]         raddr_i,
  output logic [cpf_pkg::ByteW-1:0] rdata_o
);
  import cpf_pkg::*;

  logic [ByteW-1:0] mem_q [2**AddrW];
  logic [ByteW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/cpf_writer.sv
// input side: collects characters into the current bank and closes chunks
module cpf_writer #(
  parameter int unsigned CHUNK_MAX = 15
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [cpf_pkg::ByteW-1:0] s_axis_tdata_i,
  input  logic                      s_axis_tuser_i,
  input  logic                      s_axis_tlast_i,
  input  logic [1:0]                busy_i,
  output logic                      we_o,
  output logic [((CHUNK_MAX > 1) ? $clog2(CHUNK_MAX) : 1):0] waddr_o,
  output logic [cpf_pkg::ByteW-1:0] wdata_o,
  output cpf_pkg::chunk_close_t     close_o
);
  import cpf_pkg::*;

  localparam int unsigned IdxW = (CHUNK_MAX > 1) ? $clog2(CHUNK_MAX) : 1;
  localparam int unsigned CntW = $clog2(CHUNK_MAX + 1);

  logic            bank_q, bank_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic            fire;
  logic            take;
  logic [CntW-1:0] nfill;
  logic            full;
  logic            close;

  // accept whenever the bank being filled is not waiting to be sent
  assign s_axis_tready_o = !busy_i[bank_q];
  assign fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign take  = s_axis_tuser_i && (s_axis_tdata_i != '0);
  assign nfill = fill_q + CntW'(take);
  assign full  = (nfill == CntW'(CHUNK_MAX));
  assign close = fire && (full || s_axis_tlast_i);

  // character store
  assign we_o    = fire && take;
  assign waddr_o = {bank_q, fill_q[IdxW-1:0]};
  assign wdata_o = s_axis_tdata_i;

  // hand the chunk over on fill or end of string
  always_comb begin
    close_o.valid = close;
    close_o.bank  = bank_q;
    close_o.count = ByteW'(nfill);
    close_o.term  = s_axis_tlast_i;
  end

  // fill count and bank select
  always_comb begin
    bank_d = bank_q;
    fill_d = fill_q;
    if (close) begin
      bank_d = !bank_q;
      fill_d = '0;
    end else if (fire) begin
      fill_d = nfill;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_q <= 1'b0;
      fill_q <= '0;
    end else begin
      bank_q <= bank_d;
      fill_q <= fill_d;
    end
  end

  // a full chunk is never left sitting in the bank
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < CntW'(CHUNK_MAX))
    else $error("fill count reached chunk size");

  // a stalled input never changes the fill state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> (fill_q == $past(fill_q)) && (bank_q == $past(bank_q)))
    else $error("writer state moved without a word");

  // a bank only closes into a free slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    close |-> !busy_i[bank_q])
    else $error("chunk closed into busy bank");

endmodule

### hdl/cpf_reader.sv
// output side: walks closed chunks as length, data and terminator words
module cpf_reader #(
  parameter int unsigned CHUNK_MAX = 15
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cpf_pkg::chunk_close_t     close_i,
  output logic [1:0]                busy_o,
  output logic                      re_o,
  output logic [((CHUNK_MAX > 1) ? $clog2(CHUNK_MAX) : 1):0] raddr_o,
  input  logic [cpf_pkg::ByteW-1:0] rdata_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [cpf_pkg::ByteW-1:0] m_axis_tdata_o,
  output logic                      m_axis_tlast_o
);
  import cpf_pkg::*;

  localparam int unsigned IdxW = (CHUNK_MAX > 1) ? $clog2(CHUNK_MAX) : 1;
  localparam int unsigned CntW = $clog2(CHUNK_MAX + 1);
  localparam int unsigned PosW = $clog2(CHUNK_MAX + 2);

  // bank descriptors
  logic [1:0]      busy_q, busy_d;
  logic [CntW-1:0] cnt_q [2];
  logic [1:0]      term_q;

  // sequencer
  logic            rb_q, rb_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [CntW-1:0] cur_cnt;
  logic            cur_term;
  logic [PosW-1:0] cnt_ext;
  logic [PosW-1:0] pos_m1;
  kind_e           kind;
  logic            done;

  // issue stage and output register
  logic             s1_valid_q;
  kind_e            s1_kind_q;
  logic [ByteW-1:0] s1_len_q;
  logic             m_valid_q;
  logic [ByteW-1:0] m_byte_q;
  logic             m_last_q;
  logic             out_free, s1_move, s1_free, issue;

  assign out_free = !m_valid_q || m_axis_tready_i;
  assign s1_move  = s1_valid_q && out_free;
  assign s1_free  = !s1_valid_q || s1_move;
  assign issue    = busy_q[rb_q] && s1_free;

  assign cur_cnt  = cnt_q[rb_q];
  assign cur_term = term_q[rb_q];
  assign cnt_ext  = PosW'(cur_cnt);
  assign pos_m1   = pos_q - PosW'(1);

  // decide the next word of the current chunk
  always_comb begin
    kind = KIND_TERM;
    done = 1'b0;
    pos_d = pos_q;
    if ((pos_q == '0) && (cnt_ext != '0)) begin
      kind  = KIND_LEN;
      pos_d = PosW'(1);
    end else if ((pos_q != '0) && (pos_q <= cnt_ext)) begin
      kind = KIND_DATA;
      if ((pos_q == cnt_ext) && !cur_term) begin
        done  = 1'b1;
        pos_d = '0;
      end else begin
        pos_d = pos_q + PosW'(1);
      end
    end else begin
      kind  = KIND_TERM;
      done  = 1'b1;
      pos_d = '0;
    end
  end

  assign re_o    = issue && (kind == KIND_DATA);
  assign raddr_o = {rb_q, pos_m1[IdxW-1:0]};
  assign busy_o  = busy_q;

  // bank bookkeeping
  always_comb begin
    busy_d = busy_q;
    rb_d   = rb_q;
    if (issue && done) begin
      busy_d[rb_q] = 1'b0;
      rb_d         = !rb_q;
    end
    if (close_i.valid) begin
      busy_d[close_i.bank] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= '0;
      rb_q       <= 1'b0;
      pos_q      <= '0;
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      rb_q   <= rb_d;
      if (issue) begin
        pos_q <= pos_d;
      end
      if (issue) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // descriptor and payload registers
  always_ff @(posedge clk_i) begin
    if (close_i.valid) begin
      cnt_q[close_i.bank]  <= close_i.count[CntW-1:0];
      term_q[close_i.bank] <= close_i.term;
    end
    if (issue) begin
      s1_kind_q <= kind;
      s1_len_q  <= ByteW'(cur_cnt);
    end
    if (s1_move) begin
      case (s1_kind_q)
        KIND_LEN:  m_byte_q <= s1_len_q;
        KIND_DATA: m_byte_q <= rdata_i;
        default:   m_byte_q <= '0;
      endcase
      m_last_q <= (s1_kind_q == KIND_TERM);
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_byte_q;
  assign m_axis_tlast_o  = m_last_q;

  // sequencer never runs past the terminator slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q[rb_q] |-> (pos_q <= cnt_ext + PosW'(1)))
    else $error("chunk position out of range");

  // an idle reader sits at the start of a chunk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q[rb_q] |-> (pos_q == '0))
    else $error("reader position left mid chunk");

  // the last word of a string is always the zero terminator
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_last_q) |-> (m_byte_q == '0))
    else $error("last word is not a terminator");

endmodule

### hdl/length_prefixed_chunk_framer_unit.sv
// top level of the length-prefixed chunk framer
//
// Input stream: one string character per word in tdata, tuser set when the
// word carries a character, tlast on the word that ends the string. Output
// stream: chunk length bytes followed by their data bytes, then a zero
// terminator byte with tlast set at the end of each string.
// Characters fill one of two chunk banks. A bank closes when it holds
// CHUNK_MAX characters or when the string ends; the reader then sends it
// while the writer goes on filling the other bank.
// With the reader idle, a closed chunk is first marked busy; its first byte
// then passes the issue stage and the output register before it is offered.
// Throughput: the output port sends one byte per cycle while the receiver is
// ready; a full chunk drains as CHUNK_MAX + 1 bytes and a final chunk as up
// to CHUNK_MAX + 2. Input words are taken one per cycle while the bank being
// filled is free, so the sustained input rate is set by that single output
// port (about 16 output bytes per 15 characters).
// Reset clears the fill count, the bank flags and all valid flags; chunk
// contents are not cleared. When the receiver stalls, the output byte holds,
// the reader stops, and once both banks wait the input side deasserts tready.
module length_prefixed_chunk_framer_unit #(
  parameter int unsigned CHUNK_MAX = 15
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [cpf_pkg::ByteW-1:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic                      s_axis_tuser_i,   // [0] has_char
  input  logic                      s_axis_tlast_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [cpf_pkg::ByteW-1:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic                      m_axis_tlast_o
);
  import cpf_pkg::*;

  localparam int unsigned IdxW  = (CHUNK_MAX > 1) ? $clog2(CHUNK_MAX) : 1;
  localparam int unsigned AddrW = IdxW + 1;

  logic [1:0]       busy;
  chunk_close_t     close;
  logic             we, re;
  logic [AddrW-1:0] waddr, raddr;
  logic [ByteW-1:0] wdata, rdata;

  // input side
  cpf_writer #(
    .CHUNK_MAX(CHUNK_MAX)
  ) u_writer (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .s_axis_tlast_i,
    .busy_i (busy),
    .we_o   (we),
    .waddr_o(waddr),
    .wdata_o(wdata),
    .close_o(close)
  );

  // chunk banks
  cpf_chunk_ram #(
    .AddrW(AddrW)
  ) u_ram (
    .clk_i,
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // output side
  cpf_reader #(
    .CHUNK_MAX(CHUNK_MAX)
  ) u_reader (
    .clk_i,
    .rst_ni,
    .close_i(close),
    .busy_o (busy),
    .re_o   (re),
    .raddr_o(raddr),
    .rdata_i(rdata),
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tlast_o
  );

endmodule

### dv/chunk_frame_checker.sv
// stream checker for the chunk framer: predicts the framed bytes and compares them
module chunk_frame_checker #(
  parameter int unsigned CHUNK_MAX = 15
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic [cpf_pkg::ByteW-1:0] in_data_i,   // [7:0] data_byte
  input  logic                      in_user_i,   // [0] has_char
  input  logic                      in_last_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic [cpf_pkg::ByteW-1:0] out_data_i,  // [7:0] out_byte
  input  logic                      out_last_i,
  output int unsigned               errors_o,
  output int unsigned               pending_o
);

  typedef struct packed {
    logic [cpf_pkg::ByteW-1:0] value;
    logic                      last;
  } frame_byte_t;

  // own copy of the chunk store
  logic [cpf_pkg::ByteW-1:0] chunk_chars [CHUNK_MAX];
  int unsigned               chunk_fill = 0;
  int unsigned               error_count = 0;
  frame_byte_t               frame_bytes_due [$];

  assign errors_o = error_count;

  // send the buffered chunk as a length byte and its characters
  task automatic send_chunk();
    if (chunk_fill == 0) begin
      return;
    end
    frame_bytes_due.push_back('{value: cpf_pkg::ByteW'(chunk_fill), last: 1'b0});
    for (int unsigned i = 0; i < chunk_fill; i++) begin
      frame_bytes_due.push_back('{value: chunk_chars[i], last: 1'b0});
    end
    chunk_fill = 0;
  endtask

  // one accepted input word: store a character, then handle the end of string
  task automatic frame_word(input logic [cpf_pkg::ByteW-1:0] ch, input logic has_char,
                            input logic ends);
    if (has_char && ch != '0) begin
      chunk_chars[chunk_fill] = ch;
      chunk_fill++;
      if (chunk_fill == CHUNK_MAX) begin
        send_chunk();
      end
    end
    if (ends) begin
      send_chunk();
      frame_bytes_due.push_back('{value: '0, last: 1'b1});
    end
  endtask

  // watch both channels at each rising edge
  always @(posedge clk_i) begin
    frame_byte_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        frame_word(in_data_i, in_user_i, in_last_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (frame_bytes_due.size() == 0) begin
          $display("%0t: unexpected word: expected none, got byte %h last %b",
                   $time, out_data_i, out_last_i);
          error_count++;
        end else begin
          want = frame_bytes_due.pop_front();
          if (out_data_i !== want.value) begin
            $display("%0t: byte mismatch: expected %h, got %h", $time, want.value, out_data_i);
            error_count++;
          end
          if (out_last_i !== want.last) begin
            $display("%0t: last mismatch: expected %b, got %b", $time, want.last, out_last_i);
            error_count++;
          end
        end
      end
    end
    pending_o <= frame_bytes_due.size();
  end

endmodule

### dv/testbench.sv
// testbench top: stimulus, receiver stalls and verdict for the chunk framer
module testbench;

  localparam int unsigned CHUNK_MAX   = 15;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned WORD_TARGET = 380;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [cpf_pkg::ByteW-1:0] s_tdata = '0;
  logic                      s_tuser = 1'b0;
  logic                      s_tlast = 1'b0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [cpf_pkg::ByteW-1:0] m_tdata;
  logic                      m_tlast;
  int unsigned               mismatches;
  int unsigned               bytes_pending;
  int unsigned               words_fed = 0;
  bit                        sender_calm = 1'b0;
  int unsigned               cycle_count = 0;

  always #5 clk = ~clk;

  length_prefixed_chunk_framer_unit #(
    .CHUNK_MAX(CHUNK_MAX)
  ) u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tlast_o (m_tlast)
  );

  chunk_frame_checker #(
    .CHUNK_MAX(CHUNK_MAX)
  ) u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (s_tvalid),
    .in_ready_i (s_tready),
    .in_data_i  (s_tdata),
    .in_user_i  (s_tuser),
    .in_last_i  (s_tlast),
    .out_valid_i(m_tvalid),
    .out_ready_i(m_tready),
    .out_data_i (m_tdata),
    .out_last_i (m_tlast),
    .errors_o   (mismatches),
    .pending_o  (bytes_pending)
  );

  // offer one word, with random gaps before it, and wait for its handshake
  task automatic send_word(input logic [cpf_pkg::ByteW-1:0] d, input logic has_char,
                           input logic ends);
    while (!sender_calm && $urandom_range(99) < 36) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= has_char;
    s_tlast  <= ends;
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    words_fed++;
  endtask

  // stop offering and wait until every framed byte has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (bytes_pending != 0) begin
      @(posedge clk);
    end
  endtask

  // receiver: random stalls, one long hold-off, a stretch with no stalls, then random stalls again
  initial begin
    int unsigned rx_cycle;
    rx_cycle = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle >= 300 && rx_cycle < 600) begin
        m_tready <= 1'b0;
      end else if (rx_cycle >= 620 && rx_cycle < 920) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 36);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("length_prefixed_chunk_framer_unit test failed");
      $finish;
    end
  end

  // stimulus and verdict
  initial begin
    int unsigned str_len;
    bit          mid_drained;
    mid_drained = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty string gives the terminator alone
    send_word(8'h00, 1'b0, 1'b1);
    // character carried on the end word
    send_word(8'hFF, 1'b1, 1'b1);
    // short string closed by an end word with no character
    send_word(8'h01, 1'b1, 1'b0);
    send_word(8'h80, 1'b1, 1'b0);
    send_word(8'h5A, 1'b0, 1'b1);
    // zero characters are dropped, the end is still honoured
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'h00, 1'b1, 1'b1);
    // chunk that fills exactly on the end word
    for (int i = 1; i <= 15; i++) begin
      send_word(8'(i * 17), 1'b1, i == 15);
    end
    wait_drained();

    // random strings, mostly well formed, with some noise words
    while (words_fed < WORD_TARGET) begin
      if (!mid_drained && words_fed >= 260) begin
        wait_drained();
        mid_drained = 1'b1;
      end
      sender_calm = (words_fed >= 100 && words_fed < 180);
      str_len = ($urandom_range(7) == 0) ? $urandom_range(50) : $urandom_range(20);
      repeat (str_len) begin
        if ($urandom_range(11) == 0) begin
          if ($urandom_range(1) == 1) begin
            send_word(8'($urandom), 1'b0, 1'b0);
          end else begin
            send_word(8'h00, 1'b1, 1'b0);
          end
        end
        send_word(8'($urandom_range(255, 1)), 1'b1, 1'b0);
      end
      case ($urandom_range(3))
        0, 1: send_word(8'($urandom_range(255, 1)), 1'b1, 1'b1);
        2: send_word(8'($urandom), 1'b0, 1'b1);
        default: send_word(8'h00, 1'b1, 1'b1);
      endcase
    end
    sender_calm = 1'b0;

    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("length_prefixed_chunk_framer_unit test passed");
    end else begin
      $display("length_prefixed_chunk_framer_unit test failed");
    end
    $finish;
  end

endmodule
